// File: hdl/nrn_pkg.sv
// ----------------------------------------------------------------------------
// nrn_pkg
// Shared types, codes and helpers for the nearest range navigator.
// ----------------------------------------------------------------------------
package nrn_pkg;

  localparam int MAX_SYMBOLS_DEFAULT = 256;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] DIR_DOWN  = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  // raw position bits: unsigned line, two's complement column
  typedef struct packed {
    logic [15:0] line;
    logic [15:0] col;
  } pos_t;

  typedef struct packed {
    logic [1:0] op;
    pos_t       s;
    pos_t       e;
    logic [1:0] dir;
  } item_t;

  typedef struct packed {
    logic status;
    logic found;
    pos_t s;
    pos_t e;
  } result_t;

  typedef struct packed {
    logic capture;
    logic do_clear;
    logic do_load;
    logic scan_start;
    logic scan_run;
    logic parent_phase;
    logic adjust;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] dir;
    logic       scan_done;
  } sts_t;

  // line first, then column as a signed number
  function automatic logic [31:0] ord_key(input pos_t p);
    return {p.line, ~p.col[15], p.col[14:0]};
  endfunction

  function automatic logic is_valid(input pos_t p);
    return ~p.col[15];
  endfunction

endpackage

// File: hdl/nrn_if.sv
// ----------------------------------------------------------------------------
// nrn_if
// Request and response channels of the nearest range navigator.
// ----------------------------------------------------------------------------
interface nrn_req_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  operation;
  logic        [15:0] start_line;
  logic signed [15:0] start_column;
  logic        [15:0] end_line;
  logic signed [15:0] end_column;
  logic        [1:0]  direction;

  modport source (output valid, operation, start_line, start_column, end_line,
                  end_column, direction, input ready);
  modport sink (input valid, operation, start_line, start_column, end_line,
                end_column, direction, output ready);
endinterface

interface nrn_rsp_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic               found;
  logic        [15:0] hit_start_line;
  logic signed [15:0] hit_start_column;
  logic        [15:0] hit_end_line;
  logic signed [15:0] hit_end_column;

  modport source (output valid, status, found, hit_start_line, hit_start_column,
                  hit_end_line, hit_end_column, input ready);
  modport sink (input valid, status, found, hit_start_line, hit_start_column,
                hit_end_line, hit_end_column, output ready);
endinterface

// File: hdl/nearest_range_navigator.sv
// ----------------------------------------------------------------------------
// nearest_range_navigator
// Extent table with cursor navigation queries in four directions.
// ----------------------------------------------------------------------------
// Usage: requests enter on req (valid/ready) and each gives exactly one
// response on rsp (valid/ready). operation 0 empties the table, 1 appends
// one extent (status 1 when the table is full and the extent is dropped),
// 2 queries the cursor in start_line/start_column along direction.
// Requests are handled one at a time; req.ready is high only while the
// sequencer is idle. Clear and load pass through the dispatch and finish
// states. A left or up query passes through dispatch, the match scan and
// finish; a down or right query through dispatch, the parent scan, the
// adjust state, the match scan and finish. Each scan walks the single
// table read port once, one entry per cycle, with a registered read ahead
// of the compare. The next request can be accepted once rsp.valid has
// risen: req.ready rises together with it.
// The response sits in an output register; while the receiver stalls the
// block still accepts the next request and runs it, then holds at its end
// until the register is taken. Reset empties the table (entry count zero)
// and drops any pending response; table contents are not cleared.
// ----------------------------------------------------------------------------
module nearest_range_navigator #(
  parameter int MAX_SYMBOLS = nrn_pkg::MAX_SYMBOLS_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  nrn_req_if.sink  req,
  nrn_rsp_if.source rsp
);
  import nrn_pkg::*;

  item_t   item;
  result_t result;
  cmd_t    cmd;
  sts_t    sts;

  assign item.op  = req.operation;
  assign item.s   = {req.start_line, req.start_column};
  assign item.e   = {req.end_line, req.end_column};
  assign item.dir = req.direction;

  nrn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nrn_datapath #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .result (result)
  );

  assign rsp.status           = result.status;
  assign rsp.found            = result.found;
  assign rsp.hit_start_line   = result.s.line;
  assign rsp.hit_start_column = result.s.col;
  assign rsp.hit_end_line     = result.e.line;
  assign rsp.hit_end_column   = result.e.col;

  // a new response never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!rsp.valid || rsp.ready))
    else $error("response register overwritten");

  // one request at a time
  a_single_request: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while busy");

  // a response comes no earlier than the decode cycle
  a_no_early_finish: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !cmd.finish)
    else $error("response issued without decode");

  // a dropped load never reports a match
  a_drop_not_found: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status) |-> !rsp.found)
    else $error("dropped load flagged as found");

endmodule

// File: hdl/nrn_ctrl.sv
// ----------------------------------------------------------------------------
// nrn_ctrl
// Sequencer: dispatches a request, runs the table scans, hands off the result.
// ----------------------------------------------------------------------------
module nrn_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  nrn_pkg::sts_t sts,
  output nrn_pkg::cmd_t cmd
);
  import nrn_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DISPATCH = 6'b000010,
    S_PARENT   = 6'b000100,
    S_ADJUST   = 6'b001000,
    S_MATCH    = 6'b010000,
    S_FINISH   = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   rsp_valid_r;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_CLEAR: begin
            cmd.do_clear = 1'b1;
            state_next   = S_FINISH;
          end
          OP_LOAD: begin
            cmd.do_load = 1'b1;
            state_next  = S_FINISH;
          end
          OP_QUERY: begin
            cmd.scan_start = 1'b1;
            if (sts.dir inside {DIR_DOWN, DIR_RIGHT}) state_next = S_PARENT;
            else state_next = S_MATCH;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_PARENT: begin
        cmd.scan_run     = 1'b1;
        cmd.parent_phase = 1'b1;
        if (sts.scan_done) state_next = S_ADJUST;
      end
      S_ADJUST: begin
        cmd.adjust     = 1'b1;
        cmd.scan_start = 1'b1;
        state_next     = S_MATCH;
      end
      S_MATCH: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        // output register free or being emptied this cycle
        if (!rsp_valid_r || rsp_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid_r <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) rsp_valid_r <= 1'b1;
      else if (rsp_ready) rsp_valid_r <= 1'b0;
    end
  end

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = rsp_valid_r;

endmodule

// File: hdl/nrn_datapath.sv
// ----------------------------------------------------------------------------
// nrn_datapath
// Extent table, request registers, scan comparators and result register.
// ----------------------------------------------------------------------------
module nrn_datapath #(
  parameter int MAX_SYMBOLS = nrn_pkg::MAX_SYMBOLS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  nrn_pkg::item_t   item,
  input  nrn_pkg::cmd_t    cmd,
  output nrn_pkg::sts_t    sts,
  output nrn_pkg::result_t result
);
  import nrn_pkg::*;

  localparam int CW = $clog2(MAX_SYMBOLS + 1);
  localparam int AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam logic [CW-1:0] DEPTH = CW'(MAX_SYMBOLS);

  logic [63:0]   mem [MAX_SYMBOLS];
  logic [CW-1:0] count;
  logic [CW-1:0] rd_idx;
  logic          rd_ok;
  logic          dv;
  pos_t          rd_s, rd_e;

  logic [1:0] op_r, dir_r;
  pos_t       cur, ld_s, ld_e;
  logic       hp, have, drop;
  pos_t       ps, pe, rs, re;
  result_t    res_r;

  logic [31:0] ks, ke, kc, kpe, kps, krs, kre;
  logic        par_hit, match_hit, adj_hit;

  assign rd_ok = (rd_idx != count);

  assign ks  = ord_key(rd_s);
  assign ke  = ord_key(rd_e);
  assign kc  = ord_key(cur);
  assign kpe = ord_key(pe);
  assign kps = ord_key(ps);
  assign krs = ord_key(rs);
  assign kre = ord_key(re);

  always_comb begin
    par_hit = is_valid(rd_s) && (ks <= kc) && (kc < ke) &&
              (!hp || ((ps == rd_s) ? (kpe < ke) : (kps < ks)));
    case (dir_r)
      DIR_DOWN:
        match_hit = (kc < ks) && (!hp || (ke <= kpe)) && (!have || (ks < krs));
      DIR_LEFT:
        match_hit = is_valid(rd_s) && (ke <= kc) &&
                    (!have || ((re == rd_e) ? (ks < krs) : (kre < ke)));
      DIR_RIGHT:
        match_hit = is_valid(rd_s) && (kc < ks) &&
                    (!have || ((rs == rd_s) ? (kre < ke) : (ks < krs)));
      DIR_UP:
        match_hit = is_valid(rd_s) && (ks < kc) && (kc < ke) &&
                    (!have || (krs < ks));
      default: match_hit = 1'b0;
    endcase
    adj_hit = (dir_r == DIR_RIGHT) && hp && (ps.line == cur.line) && (kc < kpe);
  end

  // table write and registered read
  always_ff @(posedge clk) begin
    if (cmd.do_load && (count < DEPTH)) mem[count[AW-1:0]] <= {ld_s, ld_e};
    if (cmd.scan_run && rd_ok) {rd_s, rd_e} <= mem[rd_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      rd_idx <= '0;
      dv     <= 1'b0;
    end else begin
      if (cmd.do_clear) count <= '0;
      else if (cmd.do_load && (count < DEPTH)) count <= count + 1'b1;
      if (cmd.scan_start) begin
        rd_idx <= '0;
        dv     <= 1'b0;
      end else if (cmd.scan_run) begin
        dv <= rd_ok;
        if (rd_ok) rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= item.op;
      dir_r <= item.dir;
      cur   <= item.s;
      ld_s  <= item.s;
      ld_e  <= item.e;
      hp    <= 1'b0;
      have  <= 1'b0;
      drop  <= 1'b0;
      ps    <= '0;
      pe    <= '0;
      rs    <= '0;
      re    <= '0;
    end
    if (cmd.do_load && !(count < DEPTH)) drop <= 1'b1;
    if (cmd.scan_run && dv) begin
      if (cmd.parent_phase) begin
        if (par_hit) begin
          ps <= rd_s;
          pe <= rd_e;
          hp <= 1'b1;
        end
      end else if (match_hit) begin
        rs   <= rd_s;
        re   <= rd_e;
        have <= 1'b1;
      end
    end
    // right: jump to the parent end, one column back when nonzero
    if (cmd.adjust && adj_hit) begin
      cur.line <= pe.line;
      cur.col  <= (pe.col != 16'd0) ? pe.col - 16'd1 : pe.col;
    end
    if (cmd.finish) begin
      res_r.status <= drop;
      res_r.found  <= have;
      res_r.s      <= rs;
      res_r.e      <= re;
    end
  end

  assign sts.op        = op_r;
  assign sts.dir       = dir_r;
  assign sts.scan_done = !rd_ok && !dv;
  assign result        = res_r;

endmodule

// File: tb/sv/nrn_answer_check.sv
// ----------------------------------------------------------------------------
// nrn_answer_check
// Watches the request and response channels of the nearest range navigator,
// keeps its own copy of the extent table, works out the answer to every
// accepted request and compares each accepted response with it, field by
// field and in order.
// ----------------------------------------------------------------------------
module nrn_answer_check #(
  parameter int DEPTH = nrn_pkg::MAX_SYMBOLS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  nrn_req_if   req,
  nrn_rsp_if   rsp,
  output int   mismatches,
  output int   awaited
);
  timeunit 1ns;
  timeprecision 1ps;
  import nrn_pkg::*;

  pos_t        ext_start [DEPTH];
  pos_t        ext_end   [DEPTH];
  int unsigned n_extents;
  result_t     awaited_answers [$];

  assign awaited = awaited_answers.size();

  // line first, then column with the sign bit flipped
  function automatic logic [31:0] pos_rank(input pos_t p);
    return {p.line, ~p.col[15], p.col[14:0]};
  endfunction

  // valid extent with start <= cursor < end and the latest start, ties to the later end
  function automatic logic enclosing_extent(input pos_t cur, output pos_t ps,
                                            output pos_t pe);
    logic have;
    have = 1'b0;
    ps = '0;
    pe = '0;
    for (int i = 0; i < n_extents; i++) begin
      if (!ext_start[i].col[15] && pos_rank(ext_start[i]) <= pos_rank(cur) &&
          pos_rank(cur) < pos_rank(ext_end[i])) begin
        if (!have || (ps == ext_start[i] ? pos_rank(pe) < pos_rank(ext_end[i])
                                         : pos_rank(ps) < pos_rank(ext_start[i]))) begin
          ps = ext_start[i];
          pe = ext_end[i];
          have = 1'b1;
        end
      end
    end
    return have;
  endfunction

  function automatic result_t navigate(input item_t it);
    result_t ans;
    pos_t    cur, ps, pe, s, e, rs, re;
    logic    have, has_parent;
    ans = '0;
    have = 1'b0;
    rs = '0;
    re = '0;
    cur = it.s;
    case (it.op)
      OP_CLEAR: n_extents = 0;
      OP_LOAD: begin
        if (n_extents < DEPTH) begin
          ext_start[n_extents] = it.s;
          ext_end[n_extents] = it.e;
          n_extents++;
        end else begin
          ans.status = 1'b1;
        end
      end
      OP_QUERY: begin
        case (it.dir)
          DIR_DOWN: begin
            has_parent = enclosing_extent(cur, ps, pe);
            // invalid extents are candidates here
            for (int i = 0; i < n_extents; i++) begin
              s = ext_start[i];
              e = ext_end[i];
              if (pos_rank(cur) < pos_rank(s) &&
                  (!has_parent || pos_rank(e) <= pos_rank(pe)) &&
                  (!have || pos_rank(s) < pos_rank(rs))) begin
                rs = s; re = e; have = 1'b1;
              end
            end
          end
          DIR_LEFT: begin
            for (int i = 0; i < n_extents; i++) begin
              s = ext_start[i];
              e = ext_end[i];
              if (!s.col[15] && pos_rank(e) <= pos_rank(cur) &&
                  (!have || (re == e ? pos_rank(s) < pos_rank(rs)
                                     : pos_rank(re) < pos_rank(e)))) begin
                rs = s; re = e; have = 1'b1;
              end
            end
          end
          DIR_RIGHT: begin
            has_parent = enclosing_extent(cur, ps, pe);
            if (has_parent && ps.line == cur.line && pos_rank(cur) < pos_rank(pe)) begin
              cur = pe;
              // step back one column, wrapping at the bottom
              if (cur.col != 16'd0) cur.col = cur.col - 16'd1;
            end
            for (int i = 0; i < n_extents; i++) begin
              s = ext_start[i];
              e = ext_end[i];
              if (!s.col[15] && pos_rank(cur) < pos_rank(s) &&
                  (!have || (s == rs ? pos_rank(re) < pos_rank(e)
                                     : pos_rank(s) < pos_rank(rs)))) begin
                rs = s; re = e; have = 1'b1;
              end
            end
          end
          default: begin
            for (int i = 0; i < n_extents; i++) begin
              s = ext_start[i];
              e = ext_end[i];
              if (!s.col[15] && pos_rank(s) < pos_rank(cur) &&
                  pos_rank(cur) < pos_rank(e) &&
                  (!have || pos_rank(rs) < pos_rank(s))) begin
                rs = s; re = e; have = 1'b1;
              end
            end
          end
        endcase
        if (have) begin
          ans.found = 1'b1;
          ans.s = rs;
          ans.e = re;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatches < 100) $display("[%0t] MISMATCH: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    item_t   it;
    result_t want;
    if (rst) begin
      n_extents = 0;
      awaited_answers.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_answers.size() == 0) begin
          flag_mismatch("response with no request outstanding");
        end else begin
          want = awaited_answers.pop_front();
          if (rsp.status !== want.status)
            flag_mismatch($sformatf("status got %b want %b", rsp.status, want.status));
          if (rsp.found !== want.found)
            flag_mismatch($sformatf("found got %b want %b", rsp.found, want.found));
          if (rsp.hit_start_line !== want.s.line)
            flag_mismatch($sformatf("hit_start_line got %h want %h",
                                    rsp.hit_start_line, want.s.line));
          if (rsp.hit_start_column !== want.s.col)
            flag_mismatch($sformatf("hit_start_column got %h want %h",
                                    rsp.hit_start_column, want.s.col));
          if (rsp.hit_end_line !== want.e.line)
            flag_mismatch($sformatf("hit_end_line got %h want %h",
                                    rsp.hit_end_line, want.e.line));
          if (rsp.hit_end_column !== want.e.col)
            flag_mismatch($sformatf("hit_end_column got %h want %h",
                                    rsp.hit_end_column, want.e.col));
        end
      end
      if (req.valid && req.ready) begin
        it.op = req.operation;
        it.s = {req.start_line, req.start_column};
        it.e = {req.end_line, req.end_column};
        it.dir = req.direction;
        awaited_answers = {awaited_answers, navigate(it)};
      end
    end
  end

endmodule

// File: tb/sv/nearest_range_navigator_tb.sv
// ----------------------------------------------------------------------------
// nearest_range_navigator_tb
// Drives clear, load, query and unused-code requests into the navigator:
// a directed opening on a small hand-built table, random sessions of loads
// and queries on small crowded grids, then a pass that fills the table and
// overflows it. Requests come in bursts, responses stall on their own pattern
// with long hold-offs; checking is done by nrn_answer_check.
// ----------------------------------------------------------------------------
module nearest_range_navigator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nrn_pkg::*;

  localparam int TABLE_DEPTH = MAX_SYMBOLS_DEFAULT;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst;
  int   mismatches;
  int   awaited;
  int   burst_left;
  int   stored;

  nrn_req_if req ();
  nrn_rsp_if rsp ();

  nearest_range_navigator #(.MAX_SYMBOLS(TABLE_DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  nrn_answer_check #(.DEPTH(TABLE_DEPTH)) answer_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic item_t make_item(input logic [1:0] op, input int sl, input int sc,
                                      input int el, input int ec, input logic [1:0] dir);
    item_t it;
    it.op = op;
    it.s = {16'(sl), 16'(sc)};
    it.e = {16'(el), 16'(ec)};
    it.dir = dir;
    return it;
  endfunction

  function automatic item_t noise_item(input logic [1:0] op);
    item_t it;
    it = {$urandom, $urandom, 4'($urandom)};
    it.op = op;
    return it;
  endfunction

  // mostly a small crowded grid so that extents nest and tie
  function automatic pos_t pick_pos(input logic [15:0] base);
    pos_t p;
    int   r;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      p.line = 16'($urandom);
      p.col = 16'($urandom);
    end else begin
      p.line = base + 16'($urandom_range(0, 7));
      if (r < 12) p.col = 16'(0 - int'($urandom_range(1, 3)));
      else p.col = 16'($urandom_range(0, 12));
    end
    return p;
  endfunction

  function automatic pos_t pick_end(input pos_t s, input logic [15:0] base);
    pos_t e;
    int   r;
    r = $urandom_range(0, 99);
    if (r < 5) return pick_pos(base);
    e.line = s.line + 16'($urandom_range(0, 3));
    if (e.line == s.line) e.col = s.col + 16'($urandom_range(0, 10));
    else if (r < 10) e.col = 16'h8000;
    else e.col = 16'($urandom_range(0, 12));
    return e;
  endfunction

  function automatic logic [15:0] pick_base();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'd65528;
      default: return 16'($urandom_range(0, 65528));
    endcase
  endfunction

  task automatic send_request(input item_t it);
    int gap;
    req.valid <= 1'b1;
    req.operation <= it.op;
    req.start_line <= it.s.line;
    req.start_column <= it.s.col;
    req.end_line <= it.e.line;
    req.end_column <= it.e.col;
    req.direction <= it.dir;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (it.op == OP_CLEAR) stored = 0;
    else if (it.op == OP_LOAD && stored < TABLE_DEPTH) stored++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 4);
    end
  endtask

  task automatic send_load(input logic [15:0] base);
    item_t it;
    it = noise_item(OP_LOAD);
    it.s = pick_pos(base);
    it.e = pick_end(it.s, base);
    send_request(it);
  endtask

  task automatic send_query(input logic [15:0] base);
    item_t it;
    it = noise_item(OP_QUERY);
    it.s = pick_pos(base);
    send_request(it);
  endtask

  // response side: segments of free flow, random stalls and long hold-offs
  initial begin
    int  seg_len, mode, cycles;
    logic long_done;
    cycles = 0;
    long_done = 1'b0;
    rsp.ready <= 1'b0;
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 9);
      seg_len = $urandom_range(10, 80);
      if ((!long_done && cycles > 300) || $urandom_range(0, 39) == 0) begin
        // sender keeps offering, so the block fills and stalls its input
        long_done = 1'b1;
        rsp.ready <= 1'b0;
        repeat (300) @(posedge clk);
        cycles += 300;
      end else begin
        repeat (seg_len) begin
          if (mode < 4) rsp.ready <= 1'b1;
          else if (mode < 8) rsp.ready <= 1'($urandom_range(0, 1));
          else rsp.ready <= ($urandom_range(0, 4) == 0);
          @(posedge clk);
          cycles++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int          random_sent, n_load, n_query, r;
    logic [15:0] base;
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.operation <= OP_CLEAR;
    req.start_line <= '0;
    req.start_column <= '0;
    req.end_line <= '0;
    req.end_column <= '0;
    req.direction <= DIR_DOWN;
    burst_left = 0;
    stored = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty table, cursor extremes, unused code
    send_request(make_item(OP_QUERY, 0, -32768, 0, 0, DIR_DOWN));
    send_request(make_item(OP_QUERY, 65535, 32767, 0, 0, DIR_UP));
    send_request(make_item(OP_UNUSED, 65535, -1, 65535, -1, DIR_UP));
    // hand-built table: nested, invalid, whole-file and wrapping extents
    send_request(make_item(OP_LOAD, 2, 0, 9, 5, DIR_DOWN));
    send_request(make_item(OP_LOAD, 3, 4, 3, 20, DIR_DOWN));
    send_request(make_item(OP_LOAD, 3, 30, 4, 2, DIR_DOWN));
    send_request(make_item(OP_LOAD, 2, -1, 3, 2, DIR_DOWN));
    send_request(make_item(OP_LOAD, 0, 0, 65535, 32767, DIR_DOWN));
    send_request(make_item(OP_LOAD, 3, 1, 6, -32768, DIR_DOWN));
    send_request(make_item(OP_LOAD, 9, 6, 9, 8, DIR_DOWN));
    send_request(make_item(OP_LOAD, 4, 5, 8, 0, DIR_DOWN));
    send_request(make_item(OP_QUERY, 3, 3, 0, 0, DIR_DOWN));
    send_request(make_item(OP_QUERY, 4, 5, 0, 0, DIR_LEFT));
    // parent end column at the bottom: step back wraps
    send_request(make_item(OP_QUERY, 3, 3, 0, 0, DIR_RIGHT));
    send_request(make_item(OP_QUERY, 2, 0, 0, 0, DIR_RIGHT));
    // parent end column zero: no step back
    send_request(make_item(OP_QUERY, 4, 6, 0, 0, DIR_RIGHT));
    send_request(make_item(OP_QUERY, 3, 5, 0, 0, DIR_UP));
    send_request(make_item(OP_QUERY, 65535, 32767, 0, 0, DIR_LEFT));
    send_request(make_item(OP_QUERY, 0, -32768, 0, 0, DIR_DOWN));
    send_request(make_item(OP_QUERY, 0, -32768, 0, 0, DIR_UP));
    send_request(make_item(OP_CLEAR, 0, 0, 0, 0, DIR_DOWN));
    send_request(make_item(OP_QUERY, 65535, 32767, 0, 0, DIR_LEFT));

    // random sessions: clear, load a small table, query it
    random_sent = 0;
    while (random_sent < 800) begin
      base = pick_base();
      if (stored > 48 || $urandom_range(0, 3) != 0) begin
        send_request(noise_item(OP_CLEAR));
        random_sent++;
      end
      n_load = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 16);
      repeat (n_load) begin
        send_load(base);
        random_sent++;
      end
      n_query = $urandom_range(3, 16);
      repeat (n_query) begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          send_request(noise_item(OP_UNUSED));
        end else begin
          if (r < 3) send_load(base);
          else send_query(base);
          random_sent++;
        end
      end
    end

    // fill the table, overflow it, and query the full table
    base = pick_base();
    send_request(noise_item(OP_CLEAR));
    repeat (TABLE_DEPTH + 4) send_load(base);
    for (int d = 0; d < 8; d++) begin
      send_request(make_item(OP_QUERY, base + 16'($urandom_range(0, 7)),
                             $urandom_range(0, 12), 0, 0, 2'(d)));
    end
    send_request(noise_item(OP_CLEAR));
    send_query(base);
    send_load(base);
    send_query(base);

    req.valid <= 1'b0;
    @(negedge clk);
    while (awaited != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/nrn_pkg.sv
hdl/nrn_if.sv
hdl/nrn_ctrl.sv
hdl/nrn_datapath.sv
hdl/nearest_range_navigator.sv
tb/sv/nrn_answer_check.sv
tb/sv/nearest_range_navigator_tb.sv
